@@ design/bpdc_pkg.sv @@
// Package for the button press duration classifier.
// Holds phase encoding, register indexes, threshold and result word types.
// No dependencies.
`default_nettype none
package bpdc_pkg;

  localparam int unsigned DEF_COUNT_WIDTH = 16;
  localparam int unsigned THR_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_THR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_THR = 2'd2;

  localparam logic [THR_W-1:0] SHORT_THR_RST     = 16'd1000;
  localparam logic [THR_W-1:0] LONG_THR_RST      = 16'd4000;
  localparam logic [THR_W-1:0] VERY_LONG_THR_RST = 16'd10000;

  localparam logic [1:0] CLASS_NONE      = 2'd0;
  localparam logic [1:0] CLASS_SHORT     = 2'd1;
  localparam logic [1:0] CLASS_LONG      = 2'd2;
  localparam logic [1:0] CLASS_VERY_LONG = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_WAIT  = 5'b00010,
    PH_SHORT = 5'b00100,
    PH_LONG  = 5'b01000,
    PH_VLONG = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0] short_thr;
    logic [THR_W-1:0] long_thr;
    logic [THR_W-1:0] very_long_thr;
  } thr_t;

  typedef struct packed {
    logic [1:0] press_class;
    logic       short_event;
    logic       long_event;
    logic       very_long_event;
    logic       release_event;
    logic       update_request;
    logic       config_request;
  } result_t;

endpackage
`default_nettype wire

@@ design/button_press_duration_classifier_top.sv @@
// A result word is registered and appears in the cycle after its tick word is accepted.
// Throughput: one word per cycle; the output register accepts a new word
// whenever it is empty or being drained in the same cycle.
// Reset (synchronous, active low): phase idle, count zero, thresholds
// 1000 / 4000 / 10000, output register empty.
// Top level of the press classifier; depends on bpdc_pkg and bpdc_step.
`default_nettype none
module button_press_duration_classifier_top #(
  parameter int unsigned COUNT_WIDTH = bpdc_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_button_pressed,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              out_press_class,
  output logic                                    out_short_event,
  output logic                                    out_long_event,
  output logic                                    out_very_long_event,
  output logic                                    out_release_event,
  output logic                                    out_update_request,
  output logic                                    out_config_request,
  input  wire logic                               cfg_we,
  input  wire logic [bpdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bpdc_pkg::THR_W-1:0]         cfg_wdata
);

  bpdc_pkg::phase_t        phase_r;
  bpdc_pkg::phase_t        phase_nxt;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic [COUNT_WIDTH-1:0]  count_nxt;
  bpdc_pkg::thr_t          thr_r;
  bpdc_pkg::result_t       res_nxt;
  bpdc_pkg::result_t       res_r;
  logic                    out_valid_r;
  logic                    accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  bpdc_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .phase     (phase_r),
    .count     (count_r),
    .pressed   (in_button_pressed),
    .thr       (thr_r),
    .phase_nxt (phase_nxt),
    .count_nxt (count_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.short_thr     <= bpdc_pkg::SHORT_THR_RST;
      thr_r.long_thr      <= bpdc_pkg::LONG_THR_RST;
      thr_r.very_long_thr <= bpdc_pkg::VERY_LONG_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpdc_pkg::REG_SHORT_THR:     thr_r.short_thr     <= cfg_wdata;
        bpdc_pkg::REG_LONG_THR:      thr_r.long_thr      <= cfg_wdata;
        bpdc_pkg::REG_VERY_LONG_THR: thr_r.very_long_thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bpdc_pkg::PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_press_class     = res_r.press_class;
  assign out_short_event     = res_r.short_event;
  assign out_long_event      = res_r.long_event;
  assign out_very_long_event = res_r.very_long_event;
  assign out_release_event   = res_r.release_event;
  assign out_update_request  = res_r.update_request;
  assign out_config_request  = res_r.config_request;

endmodule
`default_nettype wire

@@ design/bpdc_step.sv @@
// Next-state and result logic for one tick of the press classifier.
// Depends on bpdc_pkg for phase, threshold and result types.
`default_nettype none
module bpdc_step #(
  parameter int unsigned COUNT_WIDTH = bpdc_pkg::DEF_COUNT_WIDTH
) (
  input  var bpdc_pkg::phase_t         phase,
  input  wire logic [COUNT_WIDTH-1:0]  count,
  input  wire logic                    pressed,
  input  var bpdc_pkg::thr_t           thr,
  output bpdc_pkg::phase_t             phase_nxt,
  output logic      [COUNT_WIDTH-1:0]  count_nxt,
  output bpdc_pkg::result_t            res
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > bpdc_pkg::THR_W) ? COUNT_WIDTH : bpdc_pkg::THR_W;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_cmp;
  logic                   is_idle;
  logic                   st_wait;
  logic                   enter_short;
  logic                   at_short;
  logic                   enter_long;
  logic                   at_long;
  logic                   enter_vlong;
  logic                   at_vlong;

  assign is_idle = (phase != bpdc_pkg::PH_WAIT) && (phase != bpdc_pkg::PH_SHORT) &&
                   (phase != bpdc_pkg::PH_LONG) && (phase != bpdc_pkg::PH_VLONG);

  // saturating advance; a new press restarts at zero
  assign cnt_inc   = (&count) ? count : count + COUNT_WIDTH'(1);
  assign count_nxt = is_idle ? (pressed ? '0 : count) : cnt_inc;
  assign cnt_cmp   = CMP_W'(count_nxt);

  assign st_wait     = (phase == bpdc_pkg::PH_WAIT) || (is_idle && pressed);
  assign enter_short = st_wait && (cnt_cmp > CMP_W'(thr.short_thr));
  assign at_short    = (phase == bpdc_pkg::PH_SHORT) || enter_short;
  assign enter_long  = at_short && (cnt_cmp > CMP_W'(thr.long_thr));
  assign at_long     = (phase == bpdc_pkg::PH_LONG) || enter_long;
  assign enter_vlong = at_long && (cnt_cmp > CMP_W'(thr.very_long_thr));
  assign at_vlong    = (phase == bpdc_pkg::PH_VLONG) || enter_vlong;

  always_comb begin
    res                 = '0;
    res.short_event     = enter_short;
    res.long_event      = enter_long;
    res.very_long_event = enter_vlong;
    res.press_class     = bpdc_pkg::CLASS_NONE;
    phase_nxt           = bpdc_pkg::PH_IDLE;
    priority if (at_vlong) begin
      if (pressed) begin
        phase_nxt       = bpdc_pkg::PH_VLONG;
        res.press_class = bpdc_pkg::CLASS_VERY_LONG;
      end else begin
        res.release_event = 1'b1;
      end
    end else if (at_long) begin
      if (pressed) begin
        phase_nxt       = bpdc_pkg::PH_LONG;
        res.press_class = bpdc_pkg::CLASS_LONG;
      end else begin
        res.config_request = 1'b1;
      end
    end else if (at_short) begin
      if (pressed) begin
        phase_nxt       = bpdc_pkg::PH_SHORT;
        res.press_class = bpdc_pkg::CLASS_SHORT;
      end else begin
        res.update_request = 1'b1;
      end
    end else if (st_wait && pressed) begin
      phase_nxt = bpdc_pkg::PH_WAIT;
    end else begin
      phase_nxt = bpdc_pkg::PH_IDLE;
    end
  end

endmodule
`default_nettype wire

@@ design/bpdc_checker.sv @@
// Port-level checker for the press classifier, bound to the top level.
// Depends on button_press_duration_classifier_top and bpdc_pkg.
`default_nettype none
module bpdc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [1:0]                     out_press_class,
  input wire logic                           out_very_long_event,
  input wire logic                           out_release_event,
  input wire logic                           out_update_request,
  input wire logic                           out_config_request
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_one_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_release_event, out_update_request,
                              out_config_request}) <= 1)
    else $error("more than one release pulse in a word");

  a_release_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_release_event || out_update_request || out_config_request)
      |-> out_press_class == bpdc_pkg::CLASS_NONE)
    else $error("class not cleared on release");

  a_vlong_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_very_long_event
      |-> out_press_class == bpdc_pkg::CLASS_VERY_LONG || out_release_event)
    else $error("very long entry without very long class or release");

endmodule

bind button_press_duration_classifier_top bpdc_checker u_bpdc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_press_class     (out_press_class),
  .out_very_long_event (out_very_long_event),
  .out_release_event   (out_release_event),
  .out_update_request  (out_update_request),
  .out_config_request  (out_config_request)
);
`default_nettype wire

@@ tb/sv/tb_button_press_duration_classifier_top.sv @@
// Testbench for button_press_duration_classifier_top: ticks in, class words out.
// Predicts each result word in-line and checks it against the block output.
// Depends on bpdc_pkg and the classifier RTL.
`timescale 1ns / 100ps
module tb_button_press_duration_classifier_top;

  localparam int unsigned CNT_W = bpdc_pkg::DEF_COUNT_WIDTH;
  localparam logic [bpdc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam logic [bpdc_pkg::THR_W-1:0] THR_TOP = 16'd65534;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_button_pressed = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [bpdc_pkg::CFG_IDX_W-1:0] cfg_index = bpdc_pkg::REG_SHORT_THR;
  logic [bpdc_pkg::THR_W-1:0] cfg_wdata = '0;
  logic in_ready;
  logic out_valid;
  logic [1:0] out_press_class;
  logic out_short_event;
  logic out_long_event;
  logic out_very_long_event;
  logic out_release_event;
  logic out_update_request;
  logic out_config_request;

  bit tick_queue[$];
  bpdc_pkg::result_t expected_words[$];

  bpdc_pkg::phase_t press_phase = bpdc_pkg::PH_IDLE;
  logic [CNT_W-1:0] press_ticks = '0;
  logic [bpdc_pkg::THR_W-1:0] thr_short = bpdc_pkg::SHORT_THR_RST;
  logic [bpdc_pkg::THR_W-1:0] thr_long = bpdc_pkg::LONG_THR_RST;
  logic [bpdc_pkg::THR_W-1:0] thr_very_long = bpdc_pkg::VERY_LONG_THR_RST;

  int unsigned tx_idle_pct = 6;
  int unsigned rx_idle_pct = 78;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;

  button_press_duration_classifier_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_button_pressed   (in_button_pressed),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_press_class     (out_press_class),
    .out_short_event     (out_short_event),
    .out_long_event      (out_long_event),
    .out_very_long_event (out_very_long_event),
    .out_release_event   (out_release_event),
    .out_update_request  (out_update_request),
    .out_config_request  (out_config_request),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bpdc_pkg::result_t classify_tick(input bit pressed);
    bpdc_pkg::result_t r;
    bit settled;
    int unsigned step;
    r = '0;
    settled = 1'b0;
    if (press_phase != bpdc_pkg::PH_IDLE && press_ticks != '1)
      press_ticks = press_ticks + CNT_W'(1);
    for (step = 0; step < 8 && !settled; step++) begin
      case (press_phase)
        bpdc_pkg::PH_WAIT: begin
          if (press_ticks > thr_short) begin
            press_phase = bpdc_pkg::PH_SHORT;
            r.short_event = 1'b1;
          end else begin
            if (!pressed) press_phase = bpdc_pkg::PH_IDLE;
            r.press_class = bpdc_pkg::CLASS_NONE;
            settled = 1'b1;
          end
        end
        bpdc_pkg::PH_SHORT: begin
          if (press_ticks > thr_long) begin
            press_phase = bpdc_pkg::PH_LONG;
            r.long_event = 1'b1;
          end else if (!pressed) begin
            press_phase = bpdc_pkg::PH_IDLE;
            r.update_request = 1'b1;
          end else begin
            r.press_class = bpdc_pkg::CLASS_SHORT;
            settled = 1'b1;
          end
        end
        bpdc_pkg::PH_LONG: begin
          if (press_ticks > thr_very_long) begin
            press_phase = bpdc_pkg::PH_VLONG;
            r.very_long_event = 1'b1;
          end else if (!pressed) begin
            press_phase = bpdc_pkg::PH_IDLE;
            r.config_request = 1'b1;
          end else begin
            r.press_class = bpdc_pkg::CLASS_LONG;
            settled = 1'b1;
          end
        end
        bpdc_pkg::PH_VLONG: begin
          if (!pressed) begin
            press_phase = bpdc_pkg::PH_IDLE;
            r.release_event = 1'b1;
          end else begin
            r.press_class = bpdc_pkg::CLASS_VERY_LONG;
            settled = 1'b1;
          end
        end
        default: begin
          if (pressed && step == 0) begin
            press_ticks = '0;
            press_phase = bpdc_pkg::PH_WAIT;
          end else begin
            press_phase = bpdc_pkg::PH_IDLE;
            r.press_class = bpdc_pkg::CLASS_NONE;
            settled = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_button_pressed <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    bpdc_pkg::result_t got_word;
    bpdc_pkg::result_t want_word;
    if (rst_n) begin
      if (in_valid && in_ready) expected_words.push_back(classify_tick(in_button_pressed));
      if (out_valid && out_ready) begin
        got_word = {out_press_class, out_short_event, out_long_event, out_very_long_event,
                    out_release_event, out_update_request, out_config_request};
        if (expected_words.size() == 0) begin
          $error("result word with no tick pending");
          mismatches++;
        end else begin
          want_word = expected_words.pop_front();
          check_field("press_class", 32'(want_word.press_class),
                      32'(got_word.press_class));
          check_field("short_event", 32'(want_word.short_event),
                      32'(got_word.short_event));
          check_field("long_event", 32'(want_word.long_event),
                      32'(got_word.long_event));
          check_field("very_long_event", 32'(want_word.very_long_event),
                      32'(got_word.very_long_event));
          check_field("release_event", 32'(want_word.release_event),
                      32'(got_word.release_event));
          check_field("update_request", 32'(want_word.update_request),
                      32'(got_word.update_request));
          check_field("config_request", 32'(want_word.config_request),
                      32'(got_word.config_request));
        end
      end
    end
  end

  task automatic write_threshold(input logic [bpdc_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [bpdc_pkg::THR_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bpdc_pkg::REG_SHORT_THR:     thr_short = value;
      bpdc_pkg::REG_LONG_THR:      thr_long = value;
      bpdc_pkg::REG_VERY_LONG_THR: thr_very_long = value;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [bpdc_pkg::THR_W-1:0] s,
                                input logic [bpdc_pkg::THR_W-1:0] l,
                                input logic [bpdc_pkg::THR_W-1:0] v);
    write_threshold(bpdc_pkg::REG_SHORT_THR, s);
    write_threshold(bpdc_pkg::REG_LONG_THR, l);
    write_threshold(bpdc_pkg::REG_VERY_LONG_THR, v);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_words.size() != 0);
  endtask

  task automatic queue_press(input int unsigned held, input int unsigned released);
    repeat (held) tick_queue.push_back(1'b1);
    repeat (released) tick_queue.push_back(1'b0);
  endtask

  task automatic queue_random(input int unsigned n_items, input int unsigned max_len);
    int unsigned added;
    int unsigned held;
    int unsigned released;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 15) begin
        tick_queue.push_back(1'($urandom_range(1)));
        added++;
      end else begin
        held = $urandom_range(max_len, 1);
        released = $urandom_range(3, 1);
        queue_press(held, released);
        added += held + released;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_press(30, 1);
    wait_drained();

    set_thresholds(16'd2, 16'd4, 16'd6);
    tick_queue.push_back(1'b0);
    queue_press(1, 1);
    queue_press(3, 1);
    queue_press(4, 1);
    queue_press(6, 1);
    queue_press(8, 1);
    wait_drained();

    queue_random(40, 12);
    hold_reqs++;
    wait_drained();
    queue_random(40, 12);
    wait_drained();

    set_thresholds(16'd0, 16'd0, 16'd0);
    write_threshold(REG_UNUSED, 16'hFFFF);
    queue_random(30, 6);
    wait_drained();

    tx_idle_pct = 78;
    rx_idle_pct = 6;
    set_thresholds(16'd9, 16'd1, 16'd4);
    queue_random(70, 16);
    hold_reqs++;
    wait_drained();
    repeat (2) begin
      set_thresholds(16'($urandom_range(12)), 16'($urandom_range(12)), 16'($urandom_range(12)));
      queue_random(35, 20);
      wait_drained();
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_thresholds(THR_TOP, THR_TOP, THR_TOP);
    queue_random(20, 30);
    wait_drained();
    write_threshold(bpdc_pkg::REG_LONG_THR, 16'd3);
    queue_press(40, 2);
    wait_drained();

    set_thresholds(16'($urandom_range(12)), 16'($urandom_range(12)), 16'($urandom_range(12)));
    queue_random(40, 20);
    hold_reqs++;
    wait_drained();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
design/bpdc_pkg.sv
design/bpdc_step.sv
design/button_press_duration_classifier_top.sv
design/bpdc_checker.sv
tb/sv/tb_button_press_duration_classifier_top.sv
